[hw/rtl/cpualu_pkg.sv]
// ----------------------------------------------------------------------------
// cpualu_pkg
// Shared types and constants of the 8-bit cpu alu with flags: opcodes,
// flag bit positions, decimal adjust constants, operation and result records.
// ----------------------------------------------------------------------------
package cpualu_pkg;

   typedef enum logic [4:0] {
      FN_ADD   = 5'd0,
      FN_ADC   = 5'd1,
      FN_SUB   = 5'd2,
      FN_SBC   = 5'd3,
      FN_CP    = 5'd4,
      FN_AND   = 5'd5,
      FN_XOR   = 5'd6,
      FN_OR    = 5'd7,
      FN_INC   = 5'd8,
      FN_DEC   = 5'd9,
      FN_ADD16 = 5'd10,
      FN_ADDSP = 5'd11,
      FN_BIT   = 5'd12,
      FN_RL    = 5'd13,
      FN_RLC   = 5'd14,
      FN_RR    = 5'd15,
      FN_RRC   = 5'd16,
      FN_SLA   = 5'd17,
      FN_SRA   = 5'd18,
      FN_SRL   = 5'd19,
      FN_SWAP  = 5'd20,
      FN_DAA   = 5'd21
   } func_type;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam logic [7:0] DAA_LIMIT  = 8'h99;
   localparam logic [7:0] DAA_ADJ_HI = 8'h60;
   localparam logic [7:0] DAA_ADJ_LO = 8'h06;
   localparam logic [3:0] BCD_MAX    = 4'h9;

   typedef struct packed {
      logic [4:0]  func;
      logic [15:0] left;
      logic [15:0] right;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } op_type;

   typedef struct packed {
      logic        write_back;
      logic [3:0]  flags_out;
      logic [15:0] result;
   } res_type;

endpackage

[hw/rtl/cpualu_core.sv]
// ----------------------------------------------------------------------------
// cpualu_core
// Operation decode and datapath: computes the result, the new flags and the
// write-back strobe of one operation.
// ----------------------------------------------------------------------------
module cpualu_core (
   input  cpualu_pkg::op_type  op,
   output cpualu_pkg::res_type res
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic        c_add;
   logic        c_sub;
   logic [8:0]  add9;
   logic [4:0]  add_nib;
   logic [8:0]  sub9;
   logic [4:0]  sub_nib;
   logic [16:0] add17;
   logic [12:0] add13;
   logic [15:0] sp_sum;
   logic [4:0]  sp_nib;
   logic [8:0]  sp_byte;
   logic [7:0]  daa_adj;
   logic        daa_c;
   logic [7:0]  daa_val;

   assign a     = op.left[7:0];
   assign b     = op.right[7:0];
   assign cin   = op.flags_in[cpualu_pkg::FLAG_C];
   assign c_add = (cpualu_pkg::func_type'(op.func) == cpualu_pkg::FN_ADC) ? cin : 1'b0;
   assign c_sub = (cpualu_pkg::func_type'(op.func) == cpualu_pkg::FN_SBC) ? cin : 1'b0;

   assign add9    = {1'b0, a} + {1'b0, b} + {8'd0, c_add};
   assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_add};
   assign sub9    = {1'b0, a} - {1'b0, b} - {8'd0, c_sub};
   assign sub_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_sub};
   assign add17   = {1'b0, op.left} + {1'b0, op.right};
   assign add13   = {1'b0, op.left[11:0]} + {1'b0, op.right[11:0]};
   assign sp_sum  = op.left + {{8{b[7]}}, b};
   assign sp_nib  = {1'b0, op.left[3:0]} + {1'b0, b[3:0]};
   assign sp_byte = {1'b0, op.left[7:0]} + {1'b0, b};

   // decimal adjust
   always_comb begin
      daa_adj = 8'd0;
      daa_c   = cin;
      if (op.flags_in[cpualu_pkg::FLAG_N]) begin
         if (op.flags_in[cpualu_pkg::FLAG_H]) daa_adj = daa_adj | cpualu_pkg::DAA_ADJ_LO;
         if (cin) daa_adj = daa_adj | cpualu_pkg::DAA_ADJ_HI;
         daa_val = a - daa_adj;
      end else begin
         if (op.flags_in[cpualu_pkg::FLAG_H] || (a[3:0] > cpualu_pkg::BCD_MAX)) begin
            daa_adj = daa_adj | cpualu_pkg::DAA_ADJ_LO;
         end
         if (cin || (a > cpualu_pkg::DAA_LIMIT)) begin
            daa_adj = daa_adj | cpualu_pkg::DAA_ADJ_HI;
            daa_c   = 1'b1;
         end
         daa_val = a + daa_adj;
      end
   end

   always_comb begin
      logic [7:0] r8;
      logic [3:0] f;
      logic       use_z;
      r8    = 8'd0;
      f     = op.flags_in;
      use_z = 1'b1;
      res.result     = 16'd0;
      res.write_back = 1'b1;
      case (cpualu_pkg::func_type'(op.func))
         cpualu_pkg::FN_ADD, cpualu_pkg::FN_ADC: begin
            r8 = add9[7:0];
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = add_nib[4];
            f[cpualu_pkg::FLAG_C] = add9[8];
         end
         cpualu_pkg::FN_SUB, cpualu_pkg::FN_SBC, cpualu_pkg::FN_CP: begin
            r8 = sub9[7:0];
            f[cpualu_pkg::FLAG_N] = 1'b1;
            f[cpualu_pkg::FLAG_H] = sub_nib[4];
            f[cpualu_pkg::FLAG_C] = sub9[8];
         end
         cpualu_pkg::FN_AND: begin
            r8 = a & b;
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b1;
            f[cpualu_pkg::FLAG_C] = 1'b0;
         end
         cpualu_pkg::FN_XOR, cpualu_pkg::FN_OR: begin
            r8 = (cpualu_pkg::func_type'(op.func) == cpualu_pkg::FN_XOR) ? (a ^ b) : (a | b);
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b0;
            f[cpualu_pkg::FLAG_C] = 1'b0;
         end
         cpualu_pkg::FN_INC: begin
            r8 = b + 8'd1;
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = (b[3:0] == 4'hF);
         end
         cpualu_pkg::FN_DEC: begin
            r8 = b - 8'd1;
            f[cpualu_pkg::FLAG_N] = 1'b1;
            f[cpualu_pkg::FLAG_H] = (b[3:0] == 4'h0);
         end
         cpualu_pkg::FN_ADD16: begin
            use_z = 1'b0;
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = add13[12];
            f[cpualu_pkg::FLAG_C] = add17[16];
         end
         cpualu_pkg::FN_ADDSP: begin
            use_z = 1'b0;
            f[cpualu_pkg::FLAG_Z] = 1'b0;
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = sp_nib[4];
            f[cpualu_pkg::FLAG_C] = sp_byte[8];
         end
         cpualu_pkg::FN_BIT: begin
            use_z = 1'b0;
            f[cpualu_pkg::FLAG_Z] = ~b[op.bit_index];
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b1;
         end
         cpualu_pkg::FN_RL, cpualu_pkg::FN_RLC, cpualu_pkg::FN_SLA: begin
            case (cpualu_pkg::func_type'(op.func))
               cpualu_pkg::FN_RL:  r8 = {b[6:0], cin};
               cpualu_pkg::FN_RLC: r8 = {b[6:0], b[7]};
               default:            r8 = {b[6:0], 1'b0};
            endcase
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b0;
            f[cpualu_pkg::FLAG_C] = b[7];
         end
         cpualu_pkg::FN_RR, cpualu_pkg::FN_RRC, cpualu_pkg::FN_SRA,
         cpualu_pkg::FN_SRL: begin
            case (cpualu_pkg::func_type'(op.func))
               cpualu_pkg::FN_RR:  r8 = {cin, b[7:1]};
               cpualu_pkg::FN_RRC: r8 = {b[0], b[7:1]};
               cpualu_pkg::FN_SRA: r8 = {b[7], b[7:1]};
               default:            r8 = {1'b0, b[7:1]};
            endcase
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b0;
            f[cpualu_pkg::FLAG_C] = b[0];
         end
         cpualu_pkg::FN_SWAP: begin
            r8 = {b[3:0], b[7:4]};
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b0;
            f[cpualu_pkg::FLAG_C] = 1'b0;
         end
         cpualu_pkg::FN_DAA: begin
            r8 = daa_val;
            f[cpualu_pkg::FLAG_H] = 1'b0;
            f[cpualu_pkg::FLAG_C] = daa_c;
         end
         default: begin
            use_z = 1'b0;
            res.write_back = 1'b0;
         end
      endcase
      if (use_z) f[cpualu_pkg::FLAG_Z] = (r8 == 8'd0);
      case (cpualu_pkg::func_type'(op.func))
         cpualu_pkg::FN_ADD16: res.result = add17[15:0];
         cpualu_pkg::FN_ADDSP: res.result = sp_sum;
         cpualu_pkg::FN_CP, cpualu_pkg::FN_BIT: begin
            res.result     = 16'd0;
            res.write_back = 1'b0;
         end
         default: res.result = {8'd0, r8};
      endcase
      res.flags_out = f;
   end

endmodule

[hw/rtl/cpu_alu_with_flags.sv]
// path: a request beat passes the operand and result registers to its response
// throughput: one beat per cycle, set by the input and result registers
// around the single-pass datapath; back-pressure stalls both stages
// reset: synchronous, clears both stage valid bits; no other state
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// 8-bit cpu alu with z/n/h/c flags, 16-bit hl add and sp plus signed byte.
// Registered request stage, combinational datapath, registered response.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // left, right, bit_index, flags_in, zero pad
   input  logic [4:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // result, flags_out, write_back, zero pad
);

   cpualu_pkg::op_type  op_ff;
   cpualu_pkg::op_type  op_in;
   logic                op_valid_ff;
   logic                op_valid_in;
   cpualu_pkg::res_type res_ff;
   cpualu_pkg::res_type res_in;
   logic                res_valid_ff;
   logic                res_valid_in;
   logic                advance;
   logic                req_accept;

   assign advance    = ~res_valid_ff | rsp_tready;
   assign req_tready = ~op_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      op_in.func      = req_tuser;
      op_in.left      = req_tdata[15:0];
      op_in.right     = req_tdata[31:16];
      op_in.bit_index = req_tdata[34:32];
      op_in.flags_in  = req_tdata[38:35];
      op_valid_in  = req_accept | (op_valid_ff & ~advance);
      res_valid_in = advance ? op_valid_ff : res_valid_ff;
   end

   cpualu_core u_core (
      .op  (op_ff),
      .res (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff <= op_in;
      end
      if (advance && op_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {3'd0, res_ff};

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !op_valid_ff && !res_valid_ff)
      else $error("valid bits set after reset");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (op_valid_ff && !advance) |-> !req_tready)
      else $error("request taken while operand stage is stalled");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> op_valid_ff)
      else $error("accepted beat not held in operand stage");

   a_move_lands: assert property (@(posedge clock) disable iff (reset)
      (op_valid_ff && advance) |=> res_valid_ff)
      else $error("operand stage moved but no response valid");

   a_cp_bit_no_wb: assert property (@(posedge clock) disable iff (reset)
      (op_valid_ff && advance && (op_ff.func == cpualu_pkg::FN_CP
         || op_ff.func == cpualu_pkg::FN_BIT))
      |=> !res_ff.write_back && (res_ff.result == 16'd0))
      else $error("compare or bit test wrote a result");

endmodule

[bench/tb_cpu_alu_with_flags.sv]
// ----------------------------------------------------------------------------
// tb_cpu_alu_with_flags
// Stream-level testbench of the 8-bit cpu alu with flags. A short table of
// directed operations (typed-in outcomes where they are obvious) is followed
// by random operations; every response beat is compared field by field with
// an in-order queue of outcomes, typed-in or from a behavioral alu model.
// Both stream sides stall at random outside one quiet window.
// ----------------------------------------------------------------------------
module tb_cpu_alu_with_flags;

   localparam int          RAND_ITEMS  = 450;
   localparam int          CYCLE_LIMIT = 20000;
   localparam int          DRAIN_WAIT  = 8;
   localparam int          QUIET_FIRST = 150;
   localparam int          QUIET_LAST  = 350;
   localparam logic [4:0]  FN_SPARE_LO = 5'd22;
   localparam logic [4:0]  FN_SPARE_HI = 5'd31;
   localparam int          DIR_ROWS    = 25;

   typedef struct {
      logic [4:0]  func;
      logic [15:0] left;
      logic [15:0] right;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
      bit          typed;
      logic [15:0] want_result;
      logic [3:0]  want_flags;
      logic        want_wb;
   } dir_row_type;

   typedef struct {
      bit                  typed;
      cpualu_pkg::res_type want;
   } typed_outcome_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;   // left, right, bit_index, flags_in, zero pad
   logic [4:0]  req_tuser   = '0;   // func
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;          // result, flags_out, write_back, zero pad

   int cycle_count = 0;
   int fail_count  = 0;

   typed_outcome_type   typed_q[$];
   cpualu_pkg::res_type alu_outcome_q[$];

   dir_row_type dir_table [DIR_ROWS] = '{
      '{cpualu_pkg::FN_ADD,   16'h00FF, 16'h0001, 3'd0, 4'h0, 1'b1, 16'h0000, 4'hB, 1'b1},
      '{cpualu_pkg::FN_ADC,   16'hFF0F, 16'hFF00, 3'd0, 4'h1, 1'b1, 16'h0010, 4'h2, 1'b1},
      '{cpualu_pkg::FN_SUB,   16'h0000, 16'h0001, 3'd0, 4'h0, 1'b1, 16'h00FF, 4'h7, 1'b1},
      '{cpualu_pkg::FN_SBC,   16'h0010, 16'h000F, 3'd0, 4'h1, 1'b1, 16'h0000, 4'hE, 1'b1},
      '{cpualu_pkg::FN_CP,    16'h1242, 16'hAB42, 3'd0, 4'h0, 1'b1, 16'h0000, 4'hC, 1'b0},
      '{cpualu_pkg::FN_AND,   16'h00F0, 16'h000F, 3'd0, 4'hF, 1'b1, 16'h0000, 4'hA, 1'b1},
      '{cpualu_pkg::FN_XOR,   16'h00FF, 16'h00FF, 3'd0, 4'hF, 1'b1, 16'h0000, 4'h8, 1'b1},
      '{cpualu_pkg::FN_OR,    16'h0000, 16'h0000, 3'd0, 4'h7, 1'b1, 16'h0000, 4'h8, 1'b1},
      '{cpualu_pkg::FN_INC,   16'h1234, 16'h00FF, 3'd0, 4'h1, 1'b1, 16'h0000, 4'hB, 1'b1},
      '{cpualu_pkg::FN_DEC,   16'h0000, 16'hFF00, 3'd0, 4'h0, 1'b1, 16'h00FF, 4'h6, 1'b1},
      '{cpualu_pkg::FN_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'h8, 1'b1, 16'h0000, 4'hB, 1'b1},
      '{cpualu_pkg::FN_ADDSP, 16'hFFFF, 16'h0080, 3'd0, 4'hF, 1'b1, 16'hFF7F, 4'h1, 1'b1},
      '{cpualu_pkg::FN_ADDSP, 16'h0000, 16'hFF7F, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
      '{cpualu_pkg::FN_BIT,   16'hFFFF, 16'h007F, 3'd7, 4'h1, 1'b1, 16'h0000, 4'hB, 1'b0},
      '{cpualu_pkg::FN_RL,    16'h0000, 16'h0080, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h9, 1'b1},
      '{cpualu_pkg::FN_RLC,   16'h0000, 16'h0081, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
      '{cpualu_pkg::FN_RR,    16'h0000, 16'h0001, 3'd0, 4'h1, 1'b0, 16'h0000, 4'h0, 1'b0},
      '{cpualu_pkg::FN_RRC,   16'h0000, 16'h0001, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
      '{cpualu_pkg::FN_SLA,   16'h0000, 16'h00FF, 3'd0, 4'hF, 1'b0, 16'h0000, 4'h0, 1'b0},
      '{cpualu_pkg::FN_SRA,   16'h0000, 16'h0080, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
      '{cpualu_pkg::FN_SRL,   16'h0000, 16'h0001, 3'd0, 4'h0, 1'b0, 16'h0000, 4'h0, 1'b0},
      '{cpualu_pkg::FN_SWAP,  16'h0000, 16'h00F0, 3'd0, 4'h1, 1'b0, 16'h0000, 4'h0, 1'b0},
      '{cpualu_pkg::FN_DAA,   16'h009A, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'h9, 1'b1},
      '{cpualu_pkg::FN_DAA,   16'h0000, 16'h0000, 3'd0, 4'h7, 1'b1, 16'h009A, 4'h5, 1'b1},
      '{FN_SPARE_HI, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF, 1'b1, 16'h0000, 4'hF, 1'b0}
   };

   logic [15:0] corner_vals [10] = '{16'h0000, 16'h00FF, 16'h000F, 16'h0099, 16'hFFFF,
                                     16'h0080, 16'h007F, 16'h009A, 16'h0F0F, 16'h0FFF};

   cpu_alu_with_flags dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit quiet_window();
      return cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST;
   endfunction

   function automatic cpualu_pkg::res_type alu_eval(cpualu_pkg::op_type op);
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  r8;
      logic [7:0]  adj;
      logic [3:0]  f;
      logic        c;
      logic        fill;
      logic [4:0]  s5;
      logic [8:0]  s9;
      logic [12:0] s13;
      logic [16:0] s17;
      cpualu_pkg::res_type res;
      a = op.left[7:0];
      b = op.right[7:0];
      f = op.flags_in;
      r8 = '0;
      res.result = '0;
      res.write_back = 1'b1;
      case (op.func)
         cpualu_pkg::FN_ADD, cpualu_pkg::FN_ADC: begin
            c = (op.func == cpualu_pkg::FN_ADC) ? f[cpualu_pkg::FLAG_C] : 1'b0;
            s9 = {1'b0, a} + {1'b0, b} + {8'd0, c};
            s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
            r8 = s9[7:0];
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = s5[4];
            f[cpualu_pkg::FLAG_C] = s9[8];
         end
         cpualu_pkg::FN_SUB, cpualu_pkg::FN_SBC, cpualu_pkg::FN_CP: begin
            c = (op.func == cpualu_pkg::FN_SBC) ? f[cpualu_pkg::FLAG_C] : 1'b0;
            r8 = a - b - {7'd0, c};
            s5 = {1'b0, b[3:0]} + {4'd0, c};
            s9 = {1'b0, b} + {8'd0, c};
            f[cpualu_pkg::FLAG_N] = 1'b1;
            f[cpualu_pkg::FLAG_H] = {1'b0, a[3:0]} < s5;
            f[cpualu_pkg::FLAG_C] = {1'b0, a} < s9;
         end
         cpualu_pkg::FN_AND: begin
            r8 = a & b;
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b1;
            f[cpualu_pkg::FLAG_C] = 1'b0;
         end
         cpualu_pkg::FN_XOR, cpualu_pkg::FN_OR: begin
            r8 = (op.func == cpualu_pkg::FN_XOR) ? (a ^ b) : (a | b);
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b0;
            f[cpualu_pkg::FLAG_C] = 1'b0;
         end
         cpualu_pkg::FN_INC: begin
            r8 = b + 8'd1;
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = b[3:0] == 4'hF;
         end
         cpualu_pkg::FN_DEC: begin
            r8 = b - 8'd1;
            f[cpualu_pkg::FLAG_N] = 1'b1;
            f[cpualu_pkg::FLAG_H] = b[3:0] == 4'h0;
         end
         cpualu_pkg::FN_ADD16: begin
            s17 = {1'b0, op.left} + {1'b0, op.right};
            s13 = {1'b0, op.left[11:0]} + {1'b0, op.right[11:0]};
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = s13[12];
            f[cpualu_pkg::FLAG_C] = s17[16];
         end
         cpualu_pkg::FN_ADDSP: begin
            s5 = {1'b0, op.left[3:0]} + {1'b0, b[3:0]};
            s9 = {1'b0, op.left[7:0]} + {1'b0, b};
            f[cpualu_pkg::FLAG_Z] = 1'b0;
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = s5[4];
            f[cpualu_pkg::FLAG_C] = s9[8];
         end
         cpualu_pkg::FN_BIT: begin
            f[cpualu_pkg::FLAG_Z] = ~b[op.bit_index];
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b1;
         end
         cpualu_pkg::FN_RL, cpualu_pkg::FN_RLC, cpualu_pkg::FN_SLA: begin
            fill = (op.func == cpualu_pkg::FN_RL)  ? f[cpualu_pkg::FLAG_C] :
                   (op.func == cpualu_pkg::FN_RLC) ? b[7] : 1'b0;
            r8 = {b[6:0], fill};
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b0;
            f[cpualu_pkg::FLAG_C] = b[7];
         end
         cpualu_pkg::FN_RR, cpualu_pkg::FN_RRC, cpualu_pkg::FN_SRA,
         cpualu_pkg::FN_SRL: begin
            fill = (op.func == cpualu_pkg::FN_RR)  ? f[cpualu_pkg::FLAG_C] :
                   (op.func == cpualu_pkg::FN_RRC) ? b[0] :
                   (op.func == cpualu_pkg::FN_SRA) ? b[7] : 1'b0;
            r8 = {fill, b[7:1]};
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b0;
            f[cpualu_pkg::FLAG_C] = b[0];
         end
         cpualu_pkg::FN_SWAP: begin
            r8 = {b[3:0], b[7:4]};
            f[cpualu_pkg::FLAG_N] = 1'b0;
            f[cpualu_pkg::FLAG_H] = 1'b0;
            f[cpualu_pkg::FLAG_C] = 1'b0;
         end
         cpualu_pkg::FN_DAA: begin
            adj = '0;
            if (f[cpualu_pkg::FLAG_N]) begin
               if (f[cpualu_pkg::FLAG_H]) adj = adj | cpualu_pkg::DAA_ADJ_LO;
               if (f[cpualu_pkg::FLAG_C]) adj = adj | cpualu_pkg::DAA_ADJ_HI;
               r8 = a - adj;
            end else begin
               if (f[cpualu_pkg::FLAG_H] || a[3:0] > cpualu_pkg::BCD_MAX) begin
                  adj = adj | cpualu_pkg::DAA_ADJ_LO;
               end
               if (f[cpualu_pkg::FLAG_C] || a > cpualu_pkg::DAA_LIMIT) begin
                  adj = adj | cpualu_pkg::DAA_ADJ_HI;
                  f[cpualu_pkg::FLAG_C] = 1'b1;
               end
               r8 = a + adj;
            end
            f[cpualu_pkg::FLAG_H] = 1'b0;
         end
         default: res.write_back = 1'b0;
      endcase
      case (op.func)
         cpualu_pkg::FN_ADD16: res.result = s17[15:0];
         cpualu_pkg::FN_ADDSP: res.result = op.left + {{8{b[7]}}, b};
         cpualu_pkg::FN_CP: begin
            f[cpualu_pkg::FLAG_Z] = r8 == 8'h00;
            res.write_back = 1'b0;
         end
         cpualu_pkg::FN_BIT: res.write_back = 1'b0;
         default: begin
            if (op.func <= cpualu_pkg::FN_DAA) begin
               f[cpualu_pkg::FLAG_Z] = r8 == 8'h00;
               res.result = {8'h00, r8};
            end
         end
      endcase
      res.flags_out = f;
      return res;
   endfunction

   task automatic issue_op(input cpualu_pkg::op_type op, input bit typed,
                           input cpualu_pkg::res_type want);
      typed_outcome_type entry;
      while (!quiet_window() && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      entry.typed = typed;
      entry.want  = want;
      typed_q.push_back(entry);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, op.flags_in, op.bit_index, op.right, op.left};
      req_tuser  <= op.func;
      do @(posedge clock); while (!req_tready);
   endtask

   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : (quiet_window() || $urandom_range(99) >= 7);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // request beats are predicted, response beats checked in order
   always @(posedge clock) begin
      cpualu_pkg::op_type  op;
      typed_outcome_type   entry;
      cpualu_pkg::res_type got;
      cpualu_pkg::res_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            op = {req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[34:32],
                  req_tdata[38:35]};
            entry = typed_q.pop_front();
            alu_outcome_q.push_back(entry.typed ? entry.want : alu_eval(op));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.result     = rsp_tdata[15:0];
            got.flags_out  = rsp_tdata[19:16];
            got.write_back = rsp_tdata[20];
            if (alu_outcome_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response beat: result %h flags %h wb %b",
                           got.result, got.flags_out, got.write_back);
            end else begin
               want = alu_outcome_q.pop_front();
               if (got.result != want.result || got.flags_out != want.flags_out ||
                   got.write_back != want.write_back) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: result %h/%h flags %h/%h wb %b/%b (exp/act)",
                              want.result, got.result, want.flags_out, got.flags_out,
                              want.write_back, got.write_back);
               end
            end
         end
      end
   end

   initial begin
      cpualu_pkg::op_type  op;
      cpualu_pkg::res_type want;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         op.func      = dir_table[i].func;
         op.left      = dir_table[i].left;
         op.right     = dir_table[i].right;
         op.bit_index = dir_table[i].bit_index;
         op.flags_in  = dir_table[i].flags_in;
         want.result     = dir_table[i].want_result;
         want.flags_out  = dir_table[i].want_flags;
         want.write_back = dir_table[i].want_wb;
         issue_op(op, dir_table[i].typed, want);
      end

      // mostly defined operations, some spare codes, operands biased to corners
      want = '0;
      repeat (RAND_ITEMS) begin
         op.func = ($urandom_range(99) < 90) ? 5'($urandom_range(cpualu_pkg::FN_DAA))
                                             : 5'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
         op.left  = ($urandom_range(3) == 0) ? corner_vals[$urandom_range(9)]
                                             : 16'($urandom);
         op.right = ($urandom_range(3) == 0) ? corner_vals[$urandom_range(9)]
                                             : 16'($urandom);
         op.bit_index = 3'($urandom_range(7));
         op.flags_in  = 4'($urandom_range(15));
         issue_op(op, 1'b0, want);
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (alu_outcome_q.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && alu_outcome_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
